[sv/ccp_pkg.sv]
// Shared types and constants for the console command parser.
// Holds event codes, character constants and the known command name tables.
package ccp_pkg;

   // Event codes carried on the result channel
   localparam logic [2:0] EV_NONE      = 3'd0;
   localparam logic [2:0] EV_GET_DATA  = 3'd1;
   localparam logic [2:0] EV_SET_LED   = 3'd2;
   localparam logic [2:0] EV_CLR_LED   = 3'd3;
   localparam logic [2:0] EV_UNKNOWN   = 3'd4;
   localparam logic [2:0] EV_TOO_LONG  = 3'd5;
   localparam logic [2:0] EV_BAD_PARAM = 3'd6;
   localparam logic [2:0] EV_BAD_END   = 3'd7;

   localparam logic [2:0] LED_MAX = 3'd4;

   // Characters
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_FOUR   = 8'h34;

   // Known command names
   localparam int unsigned CMP_IDX_W = 4;
   typedef logic [CMP_IDX_W-1:0] cmp_idx_type;
   typedef logic [1:0] sel_type;

   localparam sel_type SEL_NONE = 2'd0;
   localparam sel_type SEL_GET  = 2'd1;
   localparam sel_type SEL_SET  = 2'd2;
   localparam sel_type SEL_CLR  = 2'd3;

   localparam cmp_idx_type GET_LEN = 4'd9;
   localparam cmp_idx_type SET_LEN = 4'd7;
   localparam cmp_idx_type CLR_LEN = 4'd9;

   typedef struct packed {
      logic done;
      logic match;
   } cmp_status_type;

   function automatic cmp_idx_type sel_len(input sel_type sel);
      cmp_idx_type len;
      unique case (sel)
         SEL_GET: len = GET_LEN;
         SEL_SET: len = SET_LEN;
         SEL_CLR: len = CLR_LEN;
         default: len = '0;
      endcase
      return len;
   endfunction

   function automatic logic [2:0] sel_event(input sel_type sel);
      logic [2:0] ev;
      unique case (sel)
         SEL_GET: ev = EV_GET_DATA;
         SEL_SET: ev = EV_SET_LED;
         SEL_CLR: ev = EV_CLR_LED;
         default: ev = EV_UNKNOWN;
      endcase
      return ev;
   endfunction

   // Expected character at a given place of a known name
   function automatic logic [7:0] exp_char(input sel_type sel, input cmp_idx_type idx);
      logic [7:0] ch;
      ch = 8'h00;
      case (sel)
         SEL_GET: begin
            case (idx)
               4'd0: ch = "g";
               4'd1: ch = "e";
               4'd2: ch = "t";
               4'd3: ch = "_";
               4'd4: ch = "s";
               4'd5: ch = "d";
               4'd6: ch = "a";
               4'd7: ch = "t";
               4'd8: ch = "a";
               default: ch = 8'h00;
            endcase
         end
         SEL_SET: begin
            case (idx)
               4'd0: ch = "s";
               4'd1: ch = "e";
               4'd2: ch = "t";
               4'd3: ch = "_";
               4'd4: ch = "l";
               4'd5: ch = "e";
               4'd6: ch = "d";
               default: ch = 8'h00;
            endcase
         end
         SEL_CLR: begin
            case (idx)
               4'd0: ch = "c";
               4'd1: ch = "l";
               4'd2: ch = "e";
               4'd3: ch = "a";
               4'd4: ch = "r";
               4'd5: ch = "_";
               4'd6: ch = "l";
               4'd7: ch = "e";
               4'd8: ch = "d";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

[sv/ccp_name_cmp.sv]
// Name store and compare sequencer for the console command parser.
// Keeps the name characters in a synchronous memory; depends on ccp_pkg.
module ccp_name_cmp #(
   parameter int unsigned DEPTH = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]             wr_data,
   input  logic                   start,
   input  ccp_pkg::sel_type       start_sel,
   output ccp_pkg::cmp_status_type status
);
   import ccp_pkg::*;

   localparam int unsigned IDX_W = $clog2(DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;

   logic [7:0]  name_mem [DEPTH];
   logic [7:0]  rdata_ff;
   logic [1:0]  state_ff, state_in;
   cmp_idx_type idx_ff, idx_in;
   sel_type     sel_ff, sel_in;
   logic        mismatch;
   logic        last;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= name_mem[IDX_W'(idx_ff)];
   end

   assign mismatch = (rdata_ff != exp_char(sel_ff, idx_ff));
   assign last     = (idx_ff == sel_len(sel_ff) - cmp_idx_type'(1));

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      sel_in       = sel_ff;
      status.done  = 1'b0;
      status.match = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in   = '0;
               sel_in   = start_sel;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (mismatch || last) begin
               status.done  = 1'b1;
               status.match = !mismatch;
               state_in     = ST_IDLE;
            end else begin
               idx_in   = idx_ff + cmp_idx_type'(1);
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      sel_ff <= sel_in;
   end

endmodule

[sv/console_command_parser.sv]
// Console command parser: one received character in, one event word out.
// Depends on ccp_pkg and ccp_name_cmp.
//
// Input channel (req_): one raw console byte per word. Result channel (rsp_):
// one word per input word, carrying an event code and an LED number.
// Commands look like /name or /name[d] ended by carriage return; a finished
// command is reported on the word that follows its carriage return.
//
// Most words give their result in the cycle after acceptance.
// The word after a carriage return that closes a known-length name starts a
// scan of the stored name, with a memory read step and a compare step per
// character, so its result waits until the scan ends. One word is in work at a
// time; req_stall is high during a scan.
// The result sits in an output register; while rsp_stall holds it, the next
// input word is not taken.
// Reset clears the phase, length, LED number and output valid. The name
// memory is not cleared; only characters written since are ever compared.
module console_command_parser #(
   parameter int unsigned MAX_NAME_LEN = 15
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [2:0] rsp_led_number
);
   import ccp_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_NAME_LEN);
   localparam int unsigned LEN_W = $clog2(MAX_NAME_LEN + 1);

   localparam logic [2:0] PH_WAIT  = 3'd0;
   localparam logic [2:0] PH_NAME  = 3'd1;
   localparam logic [2:0] PH_PARAM = 3'd2;
   localparam logic [2:0] PH_CLOSE = 3'd3;
   localparam logic [2:0] PH_CMD   = 3'd4;
   localparam logic [2:0] PH_LED   = 3'd5;

   logic [2:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [2:0]       led_ff, led_in;
   logic             busy_ff, busy_in;
   sel_type          pend_sel_ff, pend_sel_in;
   logic [2:0]       pend_led_ff, pend_led_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_event_ff, rsp_event_in;
   logic [2:0]       rsp_led_ff, rsp_led_in;

   logic             accept;
   logic             wr_en;
   logic             scan_start;
   sel_type          scan_sel;
   logic             imm_load;
   logic [2:0]       imm_ev;
   logic [2:0]       imm_led;
   logic             is_name_char;
   cmp_status_type   cmp_status;
   logic [7:0]       c;

   assign c            = req_rx_char;
   assign req_stall    = busy_ff | (rsp_valid_ff & rsp_stall);
   assign accept       = req_valid & ~req_stall;
   assign is_name_char = ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || (c == CH_UNDER);

   ccp_name_cmp #(
      .DEPTH(MAX_NAME_LEN)
   ) u_name_cmp (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (len_ff[IDX_W-1:0]),
      .wr_data   (c),
      .start     (scan_start),
      .start_sel (scan_sel),
      .status    (cmp_status)
   );

   always_comb begin
      phase_in    = phase_ff;
      len_in      = len_ff;
      led_in      = led_ff;
      pend_sel_in = pend_sel_ff;
      pend_led_in = pend_led_ff;
      wr_en       = 1'b0;
      scan_start  = 1'b0;
      scan_sel    = SEL_NONE;
      imm_load    = 1'b0;
      imm_ev      = EV_NONE;
      imm_led     = 3'd0;

      if (accept) begin
         imm_load = 1'b1;
         unique case (phase_ff) inside
            PH_NAME: begin
               if (c == CH_SLASH) begin
                  len_in = '0;
               end else if (len_ff >= LEN_W'(MAX_NAME_LEN)) begin
                  imm_ev   = EV_TOO_LONG;
                  len_in   = '0;
                  led_in   = 3'd0;
                  phase_in = PH_WAIT;
               end else if (is_name_char) begin
                  wr_en  = 1'b1;
                  len_in = len_ff + LEN_W'(1);
               end else if (c == CH_LBRACK) begin
                  phase_in = PH_PARAM;
               end else if (c == CH_CR) begin
                  phase_in = PH_CMD;
               end else begin
                  phase_in = PH_WAIT;
               end
            end
            PH_PARAM: begin
               if ((c >= CH_ONE) && (c <= CH_FOUR)) begin
                  led_in = c[2:0];
               end else if (c == CH_RBRACK) begin
                  phase_in = PH_CLOSE;
               end else begin
                  imm_ev   = EV_BAD_PARAM;
                  len_in   = '0;
                  led_in   = 3'd0;
                  phase_in = PH_WAIT;
               end
            end
            PH_CLOSE: begin
               if (c == CH_CR) begin
                  phase_in = PH_LED;
               end else begin
                  imm_ev   = EV_BAD_END;
                  len_in   = '0;
                  phase_in = PH_WAIT;
               end
            end
            PH_CMD, PH_LED: begin
               // pick the one known name whose length matches, if any
               if (phase_ff == PH_CMD) begin
                  if (len_ff == LEN_W'(GET_LEN)) scan_sel = SEL_GET;
               end else begin
                  if (len_ff == LEN_W'(SET_LEN)) scan_sel = SEL_SET;
                  else if (len_ff == LEN_W'(CLR_LEN)) scan_sel = SEL_CLR;
               end
               len_in   = '0;
               phase_in = (c == CH_SLASH) ? PH_NAME : PH_WAIT;
               if (scan_sel == SEL_NONE) begin
                  imm_ev  = EV_UNKNOWN;
                  imm_led = led_ff;
               end else begin
                  // hold the result until the name scan finishes
                  imm_load    = 1'b0;
                  scan_start  = 1'b1;
                  pend_sel_in = scan_sel;
                  pend_led_in = led_ff;
               end
            end
            default: begin
               phase_in = (c == CH_SLASH) ? PH_NAME : PH_WAIT;
            end
         endcase
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_event_in = rsp_event_ff;
      rsp_led_in   = rsp_led_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (scan_start) begin
         busy_in = 1'b1;
      end
      if (imm_load) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = imm_ev;
         rsp_led_in   = imm_led;
      end else if (busy_ff && cmp_status.done) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_event_in = cmp_status.match ? sel_event(pend_sel_ff) : EV_UNKNOWN;
         rsp_led_in   = pend_led_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         len_ff       <= '0;
         led_ff       <= 3'd0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         led_ff       <= led_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_sel_ff  <= pend_sel_in;
      pend_led_ff  <= pend_led_in;
      rsp_event_ff <= rsp_event_in;
      rsp_led_ff   <= rsp_led_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_res  = rsp_event_ff;
   assign rsp_led_number = rsp_led_ff;

endmodule

[sv/ccp_checker.sv]
// Port-level checks for the console command parser, bound to the top level.
// Depends on ccp_pkg for the event codes.
module ccp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_event_res,
   input logic [2:0] rsp_led_number
);
   import ccp_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_led_number))
      else $error("result word changed while stalled");

   // no new input word while a result is blocked
   a_no_accept_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result blocked");

   // LED number only rides on command events
   a_led_only_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_NONE || rsp_event_res == EV_TOO_LONG
         || rsp_event_res == EV_BAD_PARAM || rsp_event_res == EV_BAD_END)
      |-> rsp_led_number == 3'd0)
      else $error("LED number on non-command event");

   a_led_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_led_number <= LED_MAX)
      else $error("LED number out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind console_command_parser ccp_checker u_ccp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_event_res  (rsp_event_res),
   .rsp_led_number (rsp_led_number)
);
